[rtl/double_ended_priority_queue_assert.svh]
// Assertion macros shared by the double-ended priority queue RTL.
// Each expects a signal named clk and a synchronous reset named rst in scope.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/deq_pkg.sv]
// Types and constants for the double-ended priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package deq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic signed [VALUE_W-1:0] min_value;
    logic [COUNT_W-1:0]        count;
    logic                      empty_res;
    logic                      dropped;
  } out_t;

  // Command to every cell of one sorted chain in a cycle.
  typedef struct packed {
    logic insert;
    logic shift;
  } chain_cmd_t;

endpackage

`default_nettype wire

[rtl/deq_cell.sv]
// One cell of a sorted chain: holds a single value, kept in ascending order.
// Depends on deq_pkg for the value width and the chain command.
`default_nettype none

module deq_cell import deq_pkg::*; (
  input  wire logic                      clk,
  input  wire chain_cmd_t                cmd,
  input  wire logic signed [VALUE_W-1:0] key,
  input  wire logic                      occupied,
  input  wire logic                      prev_stays,
  input  wire logic signed [VALUE_W-1:0] prev_value,
  input  wire logic signed [VALUE_W-1:0] next_value,
  output logic signed [VALUE_W-1:0]      value,
  output logic                           stays
);

  // A held value no larger than the key stays put on an insert; equal keys
  // therefore land behind existing copies.
  assign stays = occupied && (value <= key);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!stays) begin
        value <= prev_stays ? key : prev_value;
      end
    end else if (cmd.shift) begin
      value <= next_value;
    end
  end

endmodule

`default_nettype wire

[rtl/deq_chain.sv]
// A row of deq_cell instances holding values in ascending order from cell 0.
// Depends on deq_pkg and deq_cell; occupancy comes from the shared count.
`default_nettype none

module deq_chain import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire chain_cmd_t                         cmd,
  input  wire logic signed [VALUE_W-1:0]          key,
  input  wire logic [$clog2(DEPTH+1)-1:0]         held,
  output logic signed [VALUE_W-1:0]               front
);

  localparam int HW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic                      cell_stays [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      occupied;
    logic                      prev_stays;
    logic signed [VALUE_W-1:0] prev_value;
    logic signed [VALUE_W-1:0] next_value;

    assign occupied = (held > HW'(i));

    if (i == 0) begin : g_head
      assign prev_stays = 1'b1;
      assign prev_value = key;
    end else begin : g_body
      assign prev_stays = cell_stays[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .key        (key),
      .occupied   (occupied),
      .prev_stays (prev_stays),
      .prev_value (prev_value),
      .next_value (next_value),
      .value      (cell_value[i]),
      .stays      (cell_stays[i])
    );
  end

  assign front = cell_value[0];

endmodule

`default_nettype wire

[rtl/double_ended_priority_queue.sv]
// Double-ended priority queue top level: two sorted cell chains and control.
// Depends on deq_pkg, deq_chain and double_ended_priority_queue_assert.svh.
//
// Usage: each input word on in_data carries an operation (insert, delete
// maximum, delete minimum) and a signed 32-bit value. Every accepted word
// produces exactly one output word on out_data with the largest and smallest
// held value (both 0 when empty), the count, an empty flag and a flag that
// marks an insert refused because CAPACITY values were already held.
// Deletes on an empty queue leave it unchanged; an unused operation code
// changes nothing.
// Two chains of CAPACITY cells are kept: one ascending, whose first cell is
// the minimum, and one holding inverted values, whose first cell gives the
// maximum. An insert updates both chains; a delete shifts only one chain.
// out_valid rises in the cycle after a word is accepted; one word is taken per
// cycle while the receiver takes results, the single cell update being the
// whole of the work. in_ready falls while a result waits on a stalled
// receiver, so no word is lost. Synchronous reset empties the queue and
// drops any pending result; no clearing pass is needed.
`default_nettype none

module double_ended_priority_queue import deq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  `include "double_ended_priority_queue_assert.svh"

  localparam int HW = $clog2(CAPACITY + 1);

  logic [HW-1:0]             held;
  logic [HW-1:0]             held_next;
  logic                      dropped;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      ins_ok;
  logic                      del_max_ok;
  logic                      del_min_ok;
  chain_cmd_t                asc_cmd;
  chain_cmd_t                desc_cmd;
  logic signed [VALUE_W-1:0] asc_front;
  logic signed [VALUE_W-1:0] desc_front;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (held == HW'(CAPACITY));
  assign empty    = (held == '0);

  assign ins_ok     = accept && (in_data.op == OP_INSERT) && !full;
  assign del_max_ok = accept && (in_data.op == OP_DEL_MAX) && !empty;
  assign del_min_ok = accept && (in_data.op == OP_DEL_MIN) && !empty;

  assign asc_cmd  = '{insert: ins_ok, shift: del_min_ok};
  assign desc_cmd = '{insert: ins_ok, shift: del_max_ok};

  always_comb begin
    held_next = held;
    if (ins_ok) begin
      held_next = held + HW'(1);
    end else if (del_max_ok || del_min_ok) begin
      held_next = held - HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      held <= held_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dropped <= (in_data.op == OP_INSERT) && full;
    end
  end

  deq_chain #(.DEPTH(CAPACITY)) u_asc (
    .clk   (clk),
    .cmd   (asc_cmd),
    .key   (in_data.value),
    .held  (held),
    .front (asc_front)
  );

  // Bitwise inversion reverses signed order, so this ascending chain of
  // inverted values keeps the largest value at its front.
  deq_chain #(.DEPTH(CAPACITY)) u_desc (
    .clk   (clk),
    .cmd   (desc_cmd),
    .key   (~in_data.value),
    .held  (held),
    .front (desc_front)
  );

  always_comb begin
    out_data.max_value = empty ? '0 : ~desc_front;
    out_data.min_value = empty ? '0 : asc_front;
    out_data.count     = COUNT_W'(held);
    out_data.empty_res = empty;
    out_data.dropped   = dropped;
  end

  `DEPQ_ASSERT_SAME(a_held_bound, 1'b1, held <= HW'(CAPACITY), "count exceeds capacity")
  `DEPQ_ASSERT_SAME(a_drop_full, out_valid && out_data.dropped, full, "drop while not full")
  `DEPQ_ASSERT_SAME(a_min_le_max, !empty, asc_front <= ~desc_front, "chains disagree")
  `DEPQ_ASSERT_NEXT(a_insert_grows, ins_ok, held == $past(held) + HW'(1), "insert lost")
  `DEPQ_ASSERT_NEXT(a_delete_shrinks, del_max_ok || del_min_ok,
                    held == $past(held) - HW'(1), "delete lost")

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the double-ended priority queue.
// Depends on deq_pkg and the double_ended_priority_queue RTL; an in-file class predicts results.
`default_nettype none

module testbench import deq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 545;
  localparam int SEGMENT = 110;

  // Tracks the sorted contents of the queue and the results still owed by the block.
  class depq_tracker;
    logic signed [VALUE_W-1:0] held_vals[$];
    out_t owed_results[$];
    int fault_count;
    int result_idx;

    function new();
      fault_count = 0;
      result_idx = 0;
    endfunction

    task report_mismatch(string msg);
      fault_count++;
      // Only the first few are printed so that a badly broken block does not flood the log.
      if (fault_count <= 40) begin
        $display("[%0t] result %0d: %s", $time, result_idx, msg);
      end
    endtask

    function int pending();
      return owed_results.size();
    endfunction

    function void note_word(in_t w);
      out_t res;
      int pos;
      res = '0;
      case (w.op)
        OP_INSERT: begin
          if (held_vals.size() >= DEPTH) begin
            res.dropped = 1'b1;
          end else begin
            pos = 0;
            while (pos < held_vals.size() && held_vals[pos] <= $signed(w.value)) pos++;
            held_vals.insert(pos, $signed(w.value));
          end
        end
        OP_DEL_MAX: begin
          if (held_vals.size() > 0) held_vals.delete(held_vals.size() - 1);
        end
        OP_DEL_MIN: begin
          if (held_vals.size() > 0) void'(held_vals.pop_front());
        end
        default: ;
      endcase
      if (held_vals.size() == 0) begin
        res.empty_res = 1'b1;
      end else begin
        res.max_value = held_vals[held_vals.size() - 1];
        res.min_value = held_vals[0];
      end
      res.count = COUNT_W'(held_vals.size());
      owed_results.insert(owed_results.size(), res);
    endfunction

    task check_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result word with none outstanding (%h)", got));
      end else begin
        want = owed_results.pop_front();
        if (got.max_value !== want.max_value)
          report_mismatch($sformatf("max_value %0d, wanted %0d", got.max_value, want.max_value));
        if (got.min_value !== want.min_value)
          report_mismatch($sformatf("min_value %0d, wanted %0d", got.min_value, want.min_value));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
        if (got.empty_res !== want.empty_res)
          report_mismatch($sformatf("empty_res %b, wanted %b", got.empty_res, want.empty_res));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("dropped %b, wanted %b", got.dropped, want.dropped));
      end
      result_idx++;
    endtask

    task check_drained();
      while (owed_results.size() > 0) begin
        void'(owed_results.pop_front());
        report_mismatch("result never delivered");
        result_idx++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int send_idle = 0;
  int recv_idle = 0;
  depq_tracker tracker;

  double_ended_priority_queue #(.CAPACITY(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // Both monitors read the values from before the edge, as the block itself does.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.note_word(in_data);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(out_data);
  end

  function automatic in_t make_word(logic [1:0] op, logic [VALUE_W-1:0] value);
    in_t w;
    w.op = op;
    w.value = value;
    return w;
  endfunction

  function automatic in_t random_word(int insert_pct);
    int r;
    int sel;
    logic [1:0] op;
    logic [VALUE_W-1:0] value;
    r = $urandom_range(99);
    if (r < insert_pct) op = OP_INSERT;
    else if (r < 97) op = $urandom_range(1) ? OP_DEL_MAX : OP_DEL_MIN;
    else op = OP_UNUSED;
    sel = $urandom_range(9);
    case (sel)
      0: begin
        case ($urandom_range(3))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = '0;
          default: value = '1;
        endcase
      end
      // A narrow band of values gives plenty of equal keys.
      1, 2, 3: value = VALUE_W'($signed($urandom_range(8)) - 4);
      default: value = $urandom;
    endcase
    return make_word(op, value);
  endfunction

  task automatic send_word(in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic run_random(int n_items);
    int weights[3];
    weights = '{85, 50, 15};
    for (int i = 0; i < n_items; i++) begin
      send_word(random_word(weights[(i / SEGMENT) % 3]));
    end
  endtask

  task automatic run_directed();
    send_word(make_word(OP_DEL_MAX, 32'h1234_5678));
    send_word(make_word(OP_DEL_MIN, 32'hffff_ffff));
    send_word(make_word(OP_UNUSED, 32'h7fff_ffff));
    send_word(make_word(OP_INSERT, 32'h8000_0000));
    send_word(make_word(OP_INSERT, 32'h7fff_ffff));
    send_word(make_word(OP_INSERT, 32'h0000_0000));
    send_word(make_word(OP_INSERT, 32'h0000_0000));
    send_word(make_word(OP_INSERT, 32'hffff_ffff));
    send_word(make_word(OP_UNUSED, 32'hffff_ffff));
    send_word(make_word(OP_DEL_MAX, 32'h0000_0000));
    send_word(make_word(OP_DEL_MIN, 32'h0000_0000));
    send_word(make_word(OP_DEL_MAX, 32'h0000_0000));
    send_word(make_word(OP_DEL_MIN, 32'h0000_0000));
    send_word(make_word(OP_INSERT, 32'h0000_0005));
    send_word(make_word(OP_INSERT, 32'h0000_0005));
    send_word(make_word(OP_INSERT, 32'hffff_fffb));
    send_word(make_word(OP_DEL_MIN, 32'h0000_0000));
    send_word(make_word(OP_DEL_MAX, 32'h0000_0000));
    send_word(make_word(OP_DEL_MAX, 32'h0000_0000));
    send_word(make_word(OP_DEL_MIN, 32'h0000_0000));
    send_word(make_word(OP_INSERT, 32'h8000_0001));
    send_word(make_word(OP_DEL_MAX, 32'h0000_0000));
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle = 13;
    recv_idle = 66;
    run_directed();
    wait_drained();
    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle = 66;
    recv_idle = 13;
    run_random(PHASE_ITEMS);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    run_random(PHASE_ITEMS);
    wait_drained();

    repeat (8) @(posedge clk);
    tracker.check_drained();
    if (tracker.fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
